/* design/btmx_pkg.sv */
package btmx_pkg;

  localparam int WORD_BITS_DEF  = 16;
  localparam int NODES_DEF      = 1024;
  localparam int COUNT_BITS_DEF = 16;

  localparam int OPC_W  = 2;
  localparam int VAL_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPC_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_NOP     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CLR     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 4'd2;
  localparam logic [CMD_W-1:0] CMD_RD_LINK = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STEP    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RD_CNT  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_CNT_INC = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CNT_DEC = 4'd7;
  localparam logic [CMD_W-1:0] CMD_POP_RD  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_LEAF    = 4'd10;
  localparam logic [CMD_W-1:0] CMD_CUT     = 4'd11;
  localparam logic [CMD_W-1:0] CMD_FREE    = 4'd12;
  localparam logic [CMD_W-1:0] CMD_FSTEP   = 4'd13;
  localparam logic [CMD_W-1:0] CMD_QSTEP   = 4'd14;
  localparam logic [CMD_W-1:0] CMD_QEMPTY  = 4'd15;

  typedef struct packed {
    logic [CMD_W-1:0]  code;
    logic [STAT_W-1:0] status;
    logic              result;
  } cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             root_empty;
    logic             nx_zero;
    logic             need_full;
    logic             last;
    logic             bottom;
    logic             cnt_max;
    logic             cnt_gt1;
    logic             q_dead;
    logic             clr_done;
  } stat_t;

endpackage

/* design/binary_trie_max_xor.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_opcode, in_value
// out_      output     out_valid/out_ready  out_status, out_xor_result
//
// One item is handled at a time. Each trie level costs a node-store read
// and its check, and the walk is framed by dispatch, leaf-count access and
// result hand-off.
// Remove that frees a branch adds a push, a link read and a step per node freed.
// After reset a clearing pass fills the free stack before in_ready rises.
// A result held by a stalled out_ready does not stop the next input transfer.
module binary_trie_max_xor #(
  parameter int WORD_BITS  = btmx_pkg::WORD_BITS_DEF,
  parameter int NODES      = btmx_pkg::NODES_DEF,
  parameter int COUNT_BITS = btmx_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [btmx_pkg::OPC_W-1:0]  in_opcode,
  input  logic [btmx_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [btmx_pkg::STAT_W-1:0] out_status,
  output logic [btmx_pkg::VAL_W-1:0]  out_xor_result
);

  btmx_pkg::cmd_t  cmd;
  btmx_pkg::stat_t st;

  btmx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  btmx_dp #(
    .WORD_BITS  (WORD_BITS),
    .NODES      (NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .out_status     (out_status),
    .out_xor_result (out_xor_result),
    .cmd            (cmd),
    .st             (st)
  );

endmodule

/* design/btmx_ctrl.sv */
module btmx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output btmx_pkg::cmd_t    cmd,
  input  btmx_pkg::stat_t   st
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_WRD   = 4'd3;
  localparam logic [3:0] S_WCHK  = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CCHK  = 4'd6;
  localparam logic [3:0] S_APOP  = 4'd7;
  localparam logic [3:0] S_ALLOC = 4'd8;
  localparam logic [3:0] S_LEAF  = 4'd9;
  localparam logic [3:0] S_FPUSH = 4'd10;
  localparam logic [3:0] S_FRD   = 4'd11;
  localparam logic [3:0] S_FSTEP = 4'd12;
  localparam logic [3:0] S_QRD   = 4'd13;
  localparam logic [3:0] S_QCHK  = 4'd14;
  localparam logic [3:0] S_RES   = 4'd15;

  logic [3:0]                  state_r, state_nxt;
  logic [btmx_pkg::STAT_W-1:0] res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.code      = btmx_pkg::CMD_NOP;
    cmd.status    = res_r;
    cmd.result    = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.code = btmx_pkg::CMD_CLR;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.code  = btmx_pkg::CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt = btmx_pkg::ST_OK;
        if (st.op == btmx_pkg::OP_QUERY) begin
          if (st.root_empty) begin
            cmd.code  = btmx_pkg::CMD_QEMPTY;
            state_nxt = S_RES;
          end else begin
            state_nxt = S_QRD;
          end
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        cmd.code  = btmx_pkg::CMD_RD_LINK;
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        cmd.code = btmx_pkg::CMD_STEP;
        if (st.nx_zero) begin
          if (st.op == btmx_pkg::OP_INSERT) begin
            if (st.need_full) begin
              res_nxt   = btmx_pkg::ST_FULL;
              state_nxt = S_RES;
            end else begin
              state_nxt = S_APOP;
            end
          end else begin
            res_nxt   = btmx_pkg::ST_ABSENT;
            state_nxt = S_RES;
          end
        end else if (st.last) begin
          state_nxt = (st.op == btmx_pkg::OP_FIND) ? S_RES : S_CRD;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_CRD: begin
        cmd.code  = btmx_pkg::CMD_RD_CNT;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (st.op == btmx_pkg::OP_INSERT) begin
          state_nxt = S_RES;
          if (st.cnt_max) res_nxt = btmx_pkg::ST_FULL;
          else cmd.code = btmx_pkg::CMD_CNT_INC;
        end else if (st.cnt_gt1) begin
          cmd.code  = btmx_pkg::CMD_CNT_DEC;
          state_nxt = S_RES;
        end else begin
          cmd.code  = btmx_pkg::CMD_CUT;
          state_nxt = S_FPUSH;
        end
      end
      S_APOP: begin
        cmd.code  = btmx_pkg::CMD_POP_RD;
        state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.code  = btmx_pkg::CMD_ALLOC;
        state_nxt = st.last ? S_LEAF : S_APOP;
      end
      S_LEAF: begin
        cmd.code  = btmx_pkg::CMD_LEAF;
        state_nxt = S_RES;
      end
      S_FPUSH: begin
        cmd.code  = btmx_pkg::CMD_FREE;
        state_nxt = st.bottom ? S_RES : S_FRD;
      end
      S_FRD: begin
        cmd.code  = btmx_pkg::CMD_RD_LINK;
        state_nxt = S_FSTEP;
      end
      S_FSTEP: begin
        cmd.code  = btmx_pkg::CMD_FSTEP;
        state_nxt = S_FPUSH;
      end
      S_QRD: begin
        cmd.code  = btmx_pkg::CMD_RD_LINK;
        state_nxt = S_QCHK;
      end
      S_QCHK: begin
        cmd.code  = btmx_pkg::CMD_QSTEP;
        state_nxt = (st.last || st.q_dead) ? S_RES : S_QRD;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.result    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      res_r       <= btmx_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/btmx_dp.sv */
module btmx_dp #(
  parameter int WORD_BITS  = btmx_pkg::WORD_BITS_DEF,
  parameter int NODES      = btmx_pkg::NODES_DEF,
  parameter int COUNT_BITS = btmx_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [btmx_pkg::OPC_W-1:0]  in_opcode,
  input  logic [btmx_pkg::VAL_W-1:0]  in_value,
  output logic [btmx_pkg::STAT_W-1:0] out_status,
  output logic [btmx_pkg::VAL_W-1:0]  out_xor_result,
  input  btmx_pkg::cmd_t              cmd,
  output btmx_pkg::stat_t             st
);

  localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(WORD_BITS + 1);
  localparam int LI = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int KW = 2 * NB;

  logic [btmx_pkg::OPC_W-1:0] op_r;
  logic [WORD_BITS-1:0]       wrev_r;
  logic [WORD_BITS-1:0]       xrev_r;
  logic [NB-1:0]              cur_r;
  logic [LW-1:0]              lvl_r;
  logic [KW-1:0]              lnk_r;
  logic [LW-1:0]              fork_lvl_r;
  logic [NB-1:0]              fork_node_r;
  logic [KW-1:0]              fork_lnk_r;
  logic [KW-1:0]              root_r;
  logic [NB:0]                free_top_r;
  logic [NB-1:0]              clr_r;
  logic [btmx_pkg::STAT_W-1:0] out_status_r;
  logic [btmx_pkg::VAL_W-1:0] out_xor_r;

  // Node store, leaf counts and free stack; read data is registered.
  logic [KW-1:0]         link_mem [NODES];
  logic [COUNT_BITS-1:0] cnt_mem  [NODES];
  logic [NB-1:0]         stk_mem  [NODES];
  logic [KW-1:0]         link_rd_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [NB-1:0]         stk_rd_r;

  logic [63:0]           v64;
  logic [WORD_BITS-1:0]  w_in;
  logic [WORD_BITS-1:0]  xr_w;
  logic [63:0]           xr64;
  logic [KW-1:0]         links_cur;
  logic [NB-1:0]         c0, c1, nx, other;
  logic                  bitc, fbit;
  logic [NB:0]           ft_m1;
  logic                  link_we;
  logic [NB-1:0]         link_wa;
  logic [KW-1:0]         link_wd;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic                  push_ok;
  logic [31:0]           need;

  assign v64  = 64'(in_value);
  assign w_in = v64[WORD_BITS-1:0];

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      xr_w[i] = xrev_r[WORD_BITS-1-i];
    end
  end
  assign xr64 = 64'(xr_w);

  assign links_cur = (cur_r == '0) ? root_r : link_rd_r;
  assign c0        = links_cur[NB-1:0];
  assign c1        = links_cur[KW-1:NB];
  assign bitc      = wrev_r[lvl_r[LI-1:0]];
  assign fbit      = wrev_r[fork_lvl_r[LI-1:0]];
  assign nx        = bitc ? c1 : c0;
  assign other     = bitc ? c0 : c1;
  assign ft_m1     = free_top_r - 1'b1;
  assign push_ok   = free_top_r < (NB+1)'(NODES);
  assign need      = 32'(WORD_BITS) - 32'(lvl_r);

  always_comb begin
    st.op         = op_r;
    st.root_empty = (root_r == '0);
    st.nx_zero    = (nx == '0);
    st.need_full  = need > 32'(free_top_r);
    st.last       = (lvl_r == LW'(WORD_BITS - 1));
    st.bottom     = (lvl_r == LW'(WORD_BITS));
    st.cnt_max    = (cnt_rd_r == '1);
    st.cnt_gt1    = (cnt_rd_r > COUNT_BITS'(1));
    st.q_dead     = (c0 == '0) && (c1 == '0);
    st.clr_done   = (clr_r == NB'(NODES - 2));
  end

  // Link writes: a write aimed at node 0 lands in the root register instead.
  always_comb begin
    link_we = 1'b0;
    link_wa = cur_r;
    link_wd = '0;
    cnt_we  = 1'b0;
    cnt_wd  = '0;
    case (cmd.code)
      btmx_pkg::CMD_ALLOC: begin
        link_we = 1'b1;
        link_wd = bitc ? {stk_rd_r, lnk_r[NB-1:0]} : {lnk_r[KW-1:NB], stk_rd_r};
      end
      btmx_pkg::CMD_LEAF: begin
        link_we = 1'b1;
        cnt_we  = 1'b1;
        cnt_wd  = COUNT_BITS'(1);
      end
      btmx_pkg::CMD_CUT: begin
        link_we = 1'b1;
        link_wa = fork_node_r;
        link_wd = fbit ? {{NB{1'b0}}, fork_lnk_r[NB-1:0]}
                       : {fork_lnk_r[KW-1:NB], {NB{1'b0}}};
      end
      btmx_pkg::CMD_CNT_INC: begin
        cnt_we = 1'b1;
        cnt_wd = cnt_rd_r + 1'b1;
      end
      btmx_pkg::CMD_CNT_DEC: begin
        cnt_we = 1'b1;
        cnt_wd = cnt_rd_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we && link_wa != '0) link_mem[link_wa] <= link_wd;
    if (cmd.code == btmx_pkg::CMD_RD_LINK) link_rd_r <= link_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cur_r] <= cnt_wd;
    if (cmd.code == btmx_pkg::CMD_RD_CNT) cnt_rd_r <= cnt_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.code == btmx_pkg::CMD_CLR) begin
      stk_mem[clr_r] <= clr_r + 1'b1;
    end else if (cmd.code == btmx_pkg::CMD_FREE && push_ok) begin
      stk_mem[free_top_r[NB-1:0]] <= cur_r;
    end
    if (cmd.code == btmx_pkg::CMD_POP_RD) stk_rd_r <= stk_mem[ft_m1[NB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r <= (NB+1)'(NODES - 1);
      clr_r      <= '0;
      root_r     <= '0;
    end else begin
      if (cmd.code == btmx_pkg::CMD_CLR) clr_r <= clr_r + 1'b1;
      if (link_we && link_wa == '0) root_r <= link_wd;
      if (cmd.code == btmx_pkg::CMD_ALLOC) free_top_r <= ft_m1;
      if (cmd.code == btmx_pkg::CMD_FREE && push_ok) free_top_r <= free_top_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.code)
      btmx_pkg::CMD_LOAD: begin
        op_r   <= in_opcode;
        cur_r  <= '0;
        lvl_r  <= '0;
        xrev_r <= '0;
        for (int i = 0; i < WORD_BITS; i++) begin
          wrev_r[i] <= w_in[WORD_BITS-1-i];
        end
      end
      btmx_pkg::CMD_STEP: begin
        lnk_r <= links_cur;
        // Pruning stops at the deepest two-child node on the path, or the root.
        if (lvl_r == '0 || (c0 != '0 && c1 != '0)) begin
          fork_lvl_r  <= lvl_r;
          fork_node_r <= cur_r;
          fork_lnk_r  <= links_cur;
        end
        if (nx != '0) begin
          cur_r <= nx;
          lvl_r <= lvl_r + 1'b1;
        end
      end
      btmx_pkg::CMD_ALLOC: begin
        cur_r <= stk_rd_r;
        lnk_r <= '0;
        lvl_r <= lvl_r + 1'b1;
      end
      btmx_pkg::CMD_CUT: begin
        cur_r <= fbit ? fork_lnk_r[KW-1:NB] : fork_lnk_r[NB-1:0];
        lvl_r <= fork_lvl_r + 1'b1;
      end
      btmx_pkg::CMD_FSTEP: begin
        cur_r <= nx;
        lvl_r <= lvl_r + 1'b1;
      end
      btmx_pkg::CMD_QSTEP: begin
        if (other != '0) begin
          xrev_r[lvl_r[LI-1:0]] <= 1'b1;
          cur_r                 <= other;
        end else if (nx != '0) begin
          cur_r <= nx;
        end
        lvl_r <= lvl_r + 1'b1;
      end
      btmx_pkg::CMD_QEMPTY: begin
        xrev_r <= wrev_r;
      end
      default: begin
      end
    endcase
    if (cmd.result) begin
      out_status_r <= cmd.status;
      out_xor_r    <= (op_r == btmx_pkg::OP_QUERY) ? xr64[btmx_pkg::VAL_W-1:0] : '0;
    end
  end

  assign out_status     = out_status_r;
  assign out_xor_result = out_xor_r;

endmodule

/* design/btmx_chk.sv */
module btmx_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [btmx_pkg::STAT_W-1:0] out_status,
  input logic [btmx_pkg::VAL_W-1:0]  out_xor_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_xor_result))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= btmx_pkg::ST_FULL)
    else $error("undefined status code");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is at work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("handshake active straight after reset");

endmodule

bind binary_trie_max_xor btmx_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_xor_result (out_xor_result)
);
